// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/pmsg_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsg_pkg
// Types and constants shared by the patch max Sobel gradient block.
// ----------------------------------------------------------------------------
package pmsg_pkg;

  localparam int PIX_W  = 8;   // grey value port width
  localparam int GRAD_W = 11;  // signed Sobel sum
  localparam int MAG_W  = 21;  // gx^2 + gy^2
  localparam int WIN_N  = 9;   // 3x3 neighborhood

  // Window index = (dx+1)*3 + (dy+1)
  localparam int IDX_MM = 0;
  localparam int IDX_M0 = 1;
  localparam int IDX_MP = 2;
  localparam int IDX_0M = 3;
  localparam int IDX_00 = 4;
  localparam int IDX_0P = 5;
  localparam int IDX_PM = 6;
  localparam int IDX_P0 = 7;
  localparam int IDX_PP = 8;

  // Reported gradient when no pixel of the patch qualified
  localparam logic signed [GRAD_W-1:0] NONE_GRAD = GRAD_W'(-8);

  typedef logic [WIN_N-1:0][PIX_W-1:0] pix_win_t;

  typedef struct packed {
    logic [GRAD_W-1:0] gx;
    logic [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]  mag;
  } grad_t;

endpackage

// ----- rtl/patch_max_sobel_gradient_top.sv -----
// ----------------------------------------------------------------------------
// patch_max_sobel_gradient_top
// Strongest 3x3 Sobel gradient over a patch, one pixel per transaction.
// ----------------------------------------------------------------------------
// Takes one patch pixel per transaction on the pix channel and reports, on
// the last pixel of a patch, the Sobel gx/gy pair with the largest
// gx^2 + gy^2 among the pixels that are inside the border and have all nine
// neighbors filled (first one wins a tie). If none qualified, grad_x and
// grad_y read -8 and found is 0. Throughput is one pixel per clock; the
// datapath is two register stages (input window, then running maximum plus
// result register) with the Sobel sums, squares and compare in between. The
// last pixel of a patch is held in the input window register and its result
// then loads the result register. Only a last-of-patch pixel that finds the
// result register occupied and stalled holds the input; pix_stall follows
// res_stall in the same cycle in that case. Pixels use the low PIXEL_BITS
// bits of each grey port, capped at the port width.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module patch_max_sobel_gradient_top #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_xm_ym,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_xm_y0,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_xm_yp,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_x0_ym,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_x0_y0,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_x0_yp,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_xp_ym,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_xp_y0,
  input  logic [pmsg_pkg::PIX_W-1:0]          pix_xp_yp,
  input  logic [pmsg_pkg::WIN_N-1:0]          unfilled_mask,
  input  logic                                inside_border,
  input  logic                                last_in_patch,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [pmsg_pkg::GRAD_W-1:0]  grad_x,
  output logic signed [pmsg_pkg::GRAD_W-1:0]  grad_y,
  output logic                                found
);

  // Effective pixel width is capped by the port width
  localparam int EFF_BITS = (PIXEL_BITS < pmsg_pkg::PIX_W) ? PIXEL_BITS : pmsg_pkg::PIX_W;
  localparam logic [pmsg_pkg::PIX_W-1:0] PIX_MASK = pmsg_pkg::PIX_W'((1 << EFF_BITS) - 1);

  // ---------------- stage 1: input window ----------------
  logic               s1_valid;
  logic               s1_qual;
  logic               s1_last;
  pmsg_pkg::pix_win_t s1_win;
  pmsg_pkg::pix_win_t win_in;

  // ---------------- gradient and magnitude ----------------
  pmsg_pkg::grad_t    sobel_out;

  // ---------------- running best ----------------
  logic                               have_best;
  logic signed [pmsg_pkg::GRAD_W-1:0] best_gx;
  logic signed [pmsg_pkg::GRAD_W-1:0] best_gy;
  logic [pmsg_pkg::MAG_W-1:0]         best_mag;

  // ---------------- flow control ----------------
  logic out_free;    // result register can take a transaction this cycle
  logic s1_consume;  // stage 1 item folds into the running best
  logic s1_go;       // stage 1 loads
  logic take;        // stage 1 candidate replaces the best
  logic fin_have;
  logic signed [pmsg_pkg::GRAD_W-1:0] fin_gx;
  logic signed [pmsg_pkg::GRAD_W-1:0] fin_gy;

  assign out_free   = !res_valid || !res_stall;
  assign s1_consume = s1_valid && (!s1_last || out_free);
  assign s1_go      = !s1_valid || s1_consume;
  assign pix_stall  = !s1_go;

  always_comb begin
    win_in                   = '0;
    win_in[pmsg_pkg::IDX_MM] = pix_xm_ym & PIX_MASK;
    win_in[pmsg_pkg::IDX_M0] = pix_xm_y0 & PIX_MASK;
    win_in[pmsg_pkg::IDX_MP] = pix_xm_yp & PIX_MASK;
    win_in[pmsg_pkg::IDX_0M] = pix_x0_ym & PIX_MASK;
    win_in[pmsg_pkg::IDX_00] = pix_x0_y0 & PIX_MASK;
    win_in[pmsg_pkg::IDX_0P] = pix_x0_yp & PIX_MASK;
    win_in[pmsg_pkg::IDX_PM] = pix_xp_ym & PIX_MASK;
    win_in[pmsg_pkg::IDX_P0] = pix_xp_y0 & PIX_MASK;
    win_in[pmsg_pkg::IDX_PP] = pix_xp_yp & PIX_MASK;
  end

  // Stage 1 register; a pixel qualifies when in bounds with every neighbor filled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= pix_valid;
    end
    if (s1_go) begin
      s1_win  <= win_in;
      s1_qual <= inside_border && (unfilled_mask == '0);
      s1_last <= last_in_patch;
    end
  end

  pmsg_sobel u_sobel (
    .win  (s1_win),
    .grad (sobel_out)
  );

  // Strictly larger magnitude replaces; the first qualifying pixel always lands
  assign take     = s1_qual && (!have_best || (sobel_out.mag > best_mag));
  assign fin_have = have_best || s1_qual;
  assign fin_gx   = take ? $signed(sobel_out.gx) : best_gx;
  assign fin_gy   = take ? $signed(sobel_out.gy) : best_gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_gx   <= '0;
      best_gy   <= '0;
      best_mag  <= '0;
    end else if (s1_consume) begin
      if (s1_last) begin
        // patch done: back to the empty state
        have_best <= 1'b0;
        best_gx   <= '0;
        best_gy   <= '0;
        best_mag  <= '0;
      end else if (take) begin
        have_best <= 1'b1;
        best_gx   <= $signed(sobel_out.gx);
        best_gy   <= $signed(sobel_out.gy);
        best_mag  <= sobel_out.mag;
      end
    end
  end

  // Result register: loads on a last-of-patch item, drains when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_consume && s1_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s1_consume && s1_last) begin
      found  <= fin_have;
      grad_x <= fin_have ? fin_gx : pmsg_pkg::NONE_GRAD;
      grad_y <= fin_have ? fin_gy : pmsg_pkg::NONE_GRAD;
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_IMP(a_none_value, clk, rst, res_valid && !found,
              grad_x == pmsg_pkg::NONE_GRAD && grad_y == pmsg_pkg::NONE_GRAD)
  `ASSERT_NEXT(a_patch_end, clk, rst, s1_consume && s1_last, res_valid && !have_best)
  `ASSERT_IMP(a_empty_best, clk, rst, !have_best, best_mag == '0)
  `ASSERT_IMP(a_no_stall_empty, clk, rst, !s1_valid, !pix_stall)

endmodule

// ----- rtl/pmsg_sobel.sv -----
// ----------------------------------------------------------------------------
// pmsg_sobel
// 3x3 Sobel gx/gy and squared magnitude of one registered window.
// ----------------------------------------------------------------------------
module pmsg_sobel (
  input  pmsg_pkg::pix_win_t win,
  output pmsg_pkg::grad_t    grad
);

  logic signed [pmsg_pkg::GRAD_W-1:0]   px [pmsg_pkg::WIN_N];
  logic signed [pmsg_pkg::GRAD_W-1:0]   gx;
  logic signed [pmsg_pkg::GRAD_W-1:0]   gy;
  logic signed [2*pmsg_pkg::GRAD_W-1:0] sq_x;
  logic signed [2*pmsg_pkg::GRAD_W-1:0] sq_y;

  always_comb begin
    for (int i = 0; i < pmsg_pkg::WIN_N; i++) begin
      px[i] = $signed({{(pmsg_pkg::GRAD_W - pmsg_pkg::PIX_W){1'b0}}, win[i]});
    end
  end

  // right column minus left column, weights 1,2,1
  assign gx = (px[pmsg_pkg::IDX_PM] + (px[pmsg_pkg::IDX_P0] <<< 1) + px[pmsg_pkg::IDX_PP])
            - (px[pmsg_pkg::IDX_MM] + (px[pmsg_pkg::IDX_M0] <<< 1) + px[pmsg_pkg::IDX_MP]);
  // row y+1 minus row y-1
  assign gy = (px[pmsg_pkg::IDX_MP] + (px[pmsg_pkg::IDX_0P] <<< 1) + px[pmsg_pkg::IDX_PP])
            - (px[pmsg_pkg::IDX_MM] + (px[pmsg_pkg::IDX_0M] <<< 1) + px[pmsg_pkg::IDX_PM]);

  assign sq_x = gx * gx;
  assign sq_y = gy * gy;

  assign grad.gx  = gx;
  assign grad.gy  = gy;
  // squares are non-negative and their sum stays below 2^21
  assign grad.mag = sq_x[pmsg_pkg::MAG_W-1:0] + sq_y[pmsg_pkg::MAG_W-1:0];

endmodule

// ----- sim/strongest_grad_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongest_grad_checker
// Watches the pixel and result channels of the patch max Sobel gradient
// block. It tracks the strongest gradient of each patch and compares every
// returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module strongest_grad_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  input  logic                               pix_stall,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_xm_ym,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_xm_y0,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_xm_yp,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_x0_ym,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_x0_y0,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_x0_yp,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_xp_ym,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_xp_y0,
  input  logic [pmsg_pkg::PIX_W-1:0]         pix_xp_yp,
  input  logic [pmsg_pkg::WIN_N-1:0]         unfilled_mask,
  input  logic                               inside_border,
  input  logic                               last_in_patch,
  input  logic                               res_valid,
  input  logic                               res_stall,
  input  logic signed [pmsg_pkg::GRAD_W-1:0] grad_x,
  input  logic signed [pmsg_pkg::GRAD_W-1:0] grad_y,
  input  logic                               found,
  output int                                 errors,
  output int                                 pending
);

  typedef struct packed {
    logic signed [pmsg_pkg::GRAD_W-1:0] gx;
    logic signed [pmsg_pkg::GRAD_W-1:0] gy;
    logic                               found;
  } patch_result_t;

  // strongest pair seen so far in the current patch
  logic signed [pmsg_pkg::GRAD_W-1:0] kept_gx = '0;
  logic signed [pmsg_pkg::GRAD_W-1:0] kept_gy = '0;
  logic [pmsg_pkg::MAG_W-1:0]         kept_mag = '0;
  logic                               kept_any = 1'b0;

  patch_result_t patch_results_q[$];
  int fail_cnt = 0;
  int queued = 0;

  assign errors  = fail_cnt;
  assign pending = queued;

  always @(posedge clk) begin : watch
    int gx, gy, mag;
    patch_result_t want, got;
    if (rst) begin
      kept_gx  = '0;
      kept_gy  = '0;
      kept_mag = '0;
      kept_any = 1'b0;
      patch_results_q.delete();
    end else begin
      // result side first: nothing pushed this edge can come out this edge
      if (res_valid && !res_stall) begin
        got = '{grad_x, grad_y, found};
        if (patch_results_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result with none expected: grad_x=%0d grad_y=%0d found=%0b",
                     $time, $signed(got.gx), $signed(got.gy), got.found);
        end else begin
          want = patch_results_q.pop_front();
          if (got.gx !== want.gx || got.gy !== want.gy || got.found !== want.found) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display(
                "%0t: mismatch: expected gx=%0d gy=%0d found=%0b, got gx=%0d gy=%0d found=%0b",
                $time, $signed(want.gx), $signed(want.gy), want.found,
                $signed(got.gx), $signed(got.gy), got.found);
          end
        end
      end

      if (pix_valid && !pix_stall) begin
        // qualifies only when in bounds with all nine neighbors filled
        if (inside_border && unfilled_mask == '0) begin
          gx = (int'(pix_xp_ym) + 2 * int'(pix_xp_y0) + int'(pix_xp_yp))
             - (int'(pix_xm_ym) + 2 * int'(pix_xm_y0) + int'(pix_xm_yp));
          gy = (int'(pix_xm_yp) + 2 * int'(pix_x0_yp) + int'(pix_xp_yp))
             - (int'(pix_xm_ym) + 2 * int'(pix_x0_ym) + int'(pix_xp_ym));
          mag = gx * gx + gy * gy;
          // strictly larger replaces; first qualifier always taken
          if (!kept_any || pmsg_pkg::MAG_W'(mag) > kept_mag) begin
            kept_gx  = pmsg_pkg::GRAD_W'(gx);
            kept_gy  = pmsg_pkg::GRAD_W'(gy);
            kept_mag = pmsg_pkg::MAG_W'(mag);
            kept_any = 1'b1;
          end
        end
        if (last_in_patch) begin
          if (kept_any)
            want = '{kept_gx, kept_gy, 1'b1};
          else
            want = '{pmsg_pkg::NONE_GRAD, pmsg_pkg::NONE_GRAD, 1'b0};
          patch_results_q.push_back(want);
          kept_gx  = '0;
          kept_gy  = '0;
          kept_mag = '0;
          kept_any = 1'b0;
        end
      end
    end
    queued = patch_results_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for patch_max_sobel_gradient_top. Sends a directed
// set of patches (gradient extremes, empty patches, every unfilled bit,
// ties), then random patches with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               pix_valid = 1'b0;
  logic                               pix_stall;
  logic [pmsg_pkg::PIX_W-1:0]         pix_xm_ym = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_xm_y0 = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_xm_yp = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_x0_ym = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_x0_y0 = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_x0_yp = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_xp_ym = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_xp_y0 = '0;
  logic [pmsg_pkg::PIX_W-1:0]         pix_xp_yp = '0;
  logic [pmsg_pkg::WIN_N-1:0]         unfilled_mask = '0;
  logic                               inside_border = 1'b0;
  logic                               last_in_patch = 1'b0;
  logic                               res_valid;
  logic                               res_stall = 1'b0;
  logic signed [pmsg_pkg::GRAD_W-1:0] grad_x;
  logic signed [pmsg_pkg::GRAD_W-1:0] grad_y;
  logic                               found;
  int                                 errors;
  int                                 pending;

  // high during the long stretch where neither side idles
  logic steady = 1'b0;
  // last window sent; random windows reuse or mirror it to force ties
  pmsg_pkg::pix_win_t prev_win = '0;

  always #4 clk = ~clk;

  patch_max_sobel_gradient_top dut (.*);

  strongest_grad_checker checker_i (.*);

  // Generous ceiling: the slowest plausible run is well under a tenth of this.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side backpressure: ~24% stalled cycles, none during the steady stretch.
  always @(posedge clk)
    res_stall <= !steady && ($urandom_range(0, 99) < 24);

  function automatic pmsg_pkg::pix_win_t make_win(
    input logic [pmsg_pkg::PIX_W-1:0] mm, m0, mp, zm, zz, zp, pm, p0, pp
  );
    pmsg_pkg::pix_win_t w;
    w[pmsg_pkg::IDX_MM] = mm;
    w[pmsg_pkg::IDX_M0] = m0;
    w[pmsg_pkg::IDX_MP] = mp;
    w[pmsg_pkg::IDX_0M] = zm;
    w[pmsg_pkg::IDX_00] = zz;
    w[pmsg_pkg::IDX_0P] = zp;
    w[pmsg_pkg::IDX_PM] = pm;
    w[pmsg_pkg::IDX_P0] = p0;
    w[pmsg_pkg::IDX_PP] = pp;
    return w;
  endfunction

  // Random neighborhood. A repeat of the previous window or its left/right
  // mirror (gx negated, gy kept) gives an equal magnitude, so ties are common.
  function automatic pmsg_pkg::pix_win_t random_win(input pmsg_pkg::pix_win_t last_w);
    pmsg_pkg::pix_win_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w = last_w;
    if (pick < 15)
      return w;
    if (pick < 30) begin
      w[pmsg_pkg::IDX_MM] = last_w[pmsg_pkg::IDX_PM];
      w[pmsg_pkg::IDX_PM] = last_w[pmsg_pkg::IDX_MM];
      w[pmsg_pkg::IDX_M0] = last_w[pmsg_pkg::IDX_P0];
      w[pmsg_pkg::IDX_P0] = last_w[pmsg_pkg::IDX_M0];
      w[pmsg_pkg::IDX_MP] = last_w[pmsg_pkg::IDX_PP];
      w[pmsg_pkg::IDX_PP] = last_w[pmsg_pkg::IDX_MP];
      return w;
    end
    for (int i = 0; i < pmsg_pkg::WIN_N; i++) begin
      if (pick < 50)
        w[i] = $urandom_range(0, 1) ? '1 : '0;                // rails only
      else if (pick < 65)
        w[i] = pmsg_pkg::PIX_W'($urandom_range(0, 15));       // low-contrast
      else
        w[i] = pmsg_pkg::PIX_W'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // One pixel transaction. Optional idle cycles come first; valid then stays
  // high with a fixed payload until the block takes it.
  task automatic send_pix(input pmsg_pkg::pix_win_t w,
                          input logic [pmsg_pkg::WIN_N-1:0] mask,
                          input logic ins, input logic last, input bit gaps);
    while (gaps && $urandom_range(0, 99) < 24) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid     <= 1'b1;
    pix_xm_ym     <= w[pmsg_pkg::IDX_MM];
    pix_xm_y0     <= w[pmsg_pkg::IDX_M0];
    pix_xm_yp     <= w[pmsg_pkg::IDX_MP];
    pix_x0_ym     <= w[pmsg_pkg::IDX_0M];
    pix_x0_y0     <= w[pmsg_pkg::IDX_00];
    pix_x0_yp     <= w[pmsg_pkg::IDX_0P];
    pix_xp_ym     <= w[pmsg_pkg::IDX_PM];
    pix_xp_y0     <= w[pmsg_pkg::IDX_P0];
    pix_xp_yp     <= w[pmsg_pkg::IDX_PP];
    unfilled_mask <= mask;
    inside_border <= ins;
    last_in_patch <= last;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    prev_win = w;
  endtask

  initial begin
    pmsg_pkg::pix_win_t         steep_win, faint_win;
    logic [pmsg_pkg::WIN_N-1:0] mask;
    logic                       ins;
    int                         sent, len, kind;
    bit                         calm;

    steep_win = make_win(0, 0, 0, 0, 0, 0, 255, 255, 255);
    faint_win = make_win(0, 0, 0, 0, 0, 0, 1, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---------------------------------------------------------
    // Single-pixel patches at the gradient extremes.
    send_pix(steep_win, '0, 1'b1, 1'b1, 1'b1);                               // gx max
    send_pix(make_win(255, 255, 255, 0, 0, 0, 0, 0, 0), '0, 1'b1, 1'b1, 1'b1); // gx min
    send_pix(make_win(0, 0, 255, 0, 0, 255, 0, 0, 255), '0, 1'b1, 1'b1, 1'b1); // gy max
    send_pix(make_win(255, 0, 0, 255, 0, 0, 255, 0, 0), '0, 1'b1, 1'b1, 1'b1); // gy min
    // flat window: zero magnitude but still found
    send_pix(make_win(255, 255, 255, 255, 255, 255, 255, 255, 255), '0, 1'b1, 1'b1, 1'b1);
    // largest reachable magnitude (gx 1020, gy 510)
    send_pix(make_win(0, 0, 0, 0, 0, 255, 255, 255, 255), '0, 1'b1, 1'b1, 1'b1);

    // Patch with no qualifying pixel: reports -8/-8, found low.
    send_pix(steep_win, '0, 1'b0, 1'b0, 1'b1);
    send_pix(steep_win, pmsg_pkg::WIN_N'(1) << pmsg_pkg::IDX_00, 1'b1, 1'b0, 1'b1);
    send_pix(steep_win, '1, 1'b0, 1'b1, 1'b1);

    // A faint pixel qualifies; steep ones that are out of bounds or have any
    // single unfilled neighbor must not displace it.
    send_pix(faint_win, '0, 1'b1, 1'b0, 1'b1);
    send_pix(steep_win, '0, 1'b0, 1'b0, 1'b1);
    for (int b = 0; b < pmsg_pkg::WIN_N; b++)
      send_pix(steep_win, pmsg_pkg::WIN_N'(1) << b, 1'b1, b == pmsg_pkg::WIN_N - 1, 1'b1);

    // Tie: mirrored window has the same magnitude, first one stays.
    send_pix(make_win(0, 0, 0, 0, 0, 0, 100, 100, 100), '0, 1'b1, 1'b0, 1'b1);
    send_pix(make_win(100, 100, 100, 0, 0, 0, 0, 0, 0), '0, 1'b1, 1'b1, 1'b1);

    // Last pixel is judged before the result goes out.
    send_pix(make_win(0, 0, 0, 0, 0, 0, 100, 100, 100), '0, 1'b1, 1'b0, 1'b1);
    send_pix(make_win(0, 0, 0, 0, 0, 0, 200, 200, 200), '0, 1'b1, 1'b1, 1'b1);

    // --- random patches ---------------------------------------------------
    // Mostly short patches, some long ones. Most pixels qualify so the
    // running maximum is exercised; the rest are masked or out of bounds.
    sent = 0;
    while (sent < 1300) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      for (int k = 0; k < len; k++) begin
        calm = (sent >= 500 && sent < 800);
        steady <= calm;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          mask = '0;
          ins  = 1'b1;
        end else if (kind < 80) begin
          mask = $urandom_range(0, 1)
               ? pmsg_pkg::WIN_N'(1) << $urandom_range(0, pmsg_pkg::WIN_N - 1)
               : pmsg_pkg::WIN_N'($urandom_range(1, 511));
          ins  = 1'b1;
        end else if (kind < 90) begin
          mask = '0;
          ins  = 1'b0;
        end else begin
          mask = pmsg_pkg::WIN_N'($urandom_range(1, 511));
          ins  = 1'($urandom_range(0, 1));
        end
        send_pix(random_win(prev_win), mask, ins, k == len - 1, !calm);
        sent++;
      end
    end
    pix_valid <= 1'b0;
    steady    <= 1'b0;

    // --- drain and verdict -------------------------------------------------
    // Checker updates on the rising edge; read its counts on the falling one.
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pmsg_pkg.sv
rtl/pmsg_sobel.sv
rtl/patch_max_sobel_gradient_top.sv
sim/strongest_grad_checker.sv
sim/testbench.sv
